### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is held
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/ntrm_pkg.sv
// ---------------------------------------------------------------------------
// ntrm_pkg
// types and constants of the nearest two ratio matcher
// ---------------------------------------------------------------------------
package ntrm_pkg;

    localparam int ELEM_W    = 16;
    localparam int IDX_W     = 16;
    localparam int RATIO_W   = 16;
    localparam int SQ_W      = 32;
    localparam int DIST_W    = 39;
    localparam int ONE_SHIFT = 15;
    localparam int PROD_W    = DIST_W + RATIO_W;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = 2;
    localparam int QCNT_W    = 3;

    localparam logic [RATIO_W-1:0] RATIO_RESET = 16'd19661;
    localparam logic [DIST_W-1:0]  DIST_MAX    = {DIST_W{1'b1}};
    localparam logic [1:0]         SEEN_MAX    = 2'd2;

    localparam logic CMD_QUERY = 1'b0;
    localparam logic CMD_CAND  = 1'b1;

    typedef struct packed {
        logic                     cmd;
        logic signed [ELEM_W-1:0] elem;
        logic signed [ELEM_W-1:0] qval;
        logic [IDX_W-1:0]         idx;
        logic                     last_elem;
        logic                     last_cand;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

### rtl/nearest_two_ratio_matcher.sv
// ---------------------------------------------------------------------------
// nearest_two_ratio_matcher
// nearest neighbour ratio test of one query descriptor against candidates
//
//   channel   handshake                  payload
//   request   item_valid / item_stall    cmd elem_value cand_index last_elem last_cand
//   result    result_valid / result_stall match_found match_index
//   config    ratio_we                   ratio_wdata
//
// one request a cycle sustained when not stalled, set by the single query store port
// results pass front, queue, squaring, search, snapshot, product and result registers
// reset clears control and search state; the query store needs loading first
// a stalled result holds the back pipeline; the queue then fills and stalls requests
// ---------------------------------------------------------------------------
module nearest_two_ratio_matcher #(
    parameter int DESC_LEN   = 64,
    parameter int INDEX_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_stall,
    input  logic                               cmd,
    input  logic signed [ntrm_pkg::ELEM_W-1:0] elem_value,
    input  logic [ntrm_pkg::IDX_W-1:0]         cand_index,
    input  logic                               last_elem,
    input  logic                               last_cand,
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic                               match_found,
    output logic [ntrm_pkg::IDX_W-1:0]         match_index,
    input  logic                               ratio_we,
    input  logic [ntrm_pkg::RATIO_W-1:0]       ratio_wdata
);
    import ntrm_pkg::*;

    logic               push;
    logic               pop;
    item_t              push_item;
    item_t              head_item;
    qstat_t             qstat;
    logic [RATIO_W-1:0] ratio_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ratio_reg <= RATIO_RESET;
        else if (ratio_we)
            ratio_reg <= ratio_wdata;
    end

    ntrm_front #(
        .DESC_LEN   (DESC_LEN),
        .INDEX_BITS (INDEX_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .cmd        (cmd),
        .elem_value (elem_value),
        .cand_index (cand_index),
        .last_elem  (last_elem),
        .last_cand  (last_cand),
        .push       (push),
        .push_item  (push_item),
        .qstat      (qstat)
    );

    ntrm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .qstat     (qstat)
    );

    ntrm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_item    (head_item),
        .qstat        (qstat),
        .pop          (pop),
        .ratio        (ratio_reg),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .match_found  (match_found),
        .match_index  (match_index)
    );

endmodule

### rtl/ntrm_front.sv
// ---------------------------------------------------------------------------
// ntrm_front
// accepts requests, keeps the element position and the query store
// ---------------------------------------------------------------------------
module ntrm_front #(
    parameter int DESC_LEN   = 64,
    parameter int INDEX_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  logic                              cmd,
    input  logic signed [ntrm_pkg::ELEM_W-1:0] elem_value,
    input  logic [ntrm_pkg::IDX_W-1:0]        cand_index,
    input  logic                              last_elem,
    input  logic                              last_cand,
    output logic                              push,
    output ntrm_pkg::item_t                   push_item,
    input  ntrm_pkg::qstat_t                  qstat
);
    import ntrm_pkg::*;

    localparam int POS_W = $clog2(DESC_LEN);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(DESC_LEN - 1);
    localparam logic [IDX_W-1:0] IDX_MASK =
        (INDEX_BITS >= IDX_W) ? {IDX_W{1'b1}} : IDX_W'((33'd1 << INDEX_BITS) - 33'd1);

    logic signed [ELEM_W-1:0] qmem [DESC_LEN];

    logic                     accept;
    logic [POS_W-1:0]         pos_reg;
    logic [POS_W-1:0]         pos_next;
    logic                     stage_valid_reg;
    logic                     stage_valid_next;
    logic                     cmd_reg;
    logic signed [ELEM_W-1:0] elem_reg;
    logic signed [ELEM_W-1:0] qval_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic                     last_elem_reg;
    logic                     last_cand_reg;

    assign item_stall = stage_valid_reg && qstat.full;
    assign accept     = item_valid && !item_stall;
    assign push       = stage_valid_reg && !qstat.full;

    always_comb
    begin
        pos_next = pos_reg;
        if (accept)
        begin
            if (last_elem || pos_reg == LAST_POS)
                pos_next = '0;
            else
                pos_next = pos_reg + POS_W'(1);
        end
        stage_valid_next = stage_valid_reg;
        if (accept)
            stage_valid_next = 1'b1;
        else if (push)
            stage_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= '0;
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg         <= pos_next;
            stage_valid_reg <= stage_valid_next;
        end
    end

    // query store, written on query loads, read on every accepted request
    always_ff @(posedge clk)
    begin
        if (accept && cmd == CMD_QUERY)
            qmem[pos_reg] <= elem_value;
        if (accept)
            qval_reg <= qmem[pos_reg];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg       <= cmd;
            elem_reg      <= elem_value;
            idx_reg       <= cand_index & IDX_MASK;
            last_elem_reg <= last_elem;
            last_cand_reg <= last_cand;
        end
    end

    always_comb
    begin
        push_item.cmd       = cmd_reg;
        push_item.elem      = elem_reg;
        push_item.qval      = qval_reg;
        push_item.idx       = idx_reg;
        push_item.last_elem = last_elem_reg;
        push_item.last_cand = last_cand_reg;
    end

endmodule

### rtl/ntrm_queue.sv
// ---------------------------------------------------------------------------
// ntrm_queue
// short queue between the front and the back
// ---------------------------------------------------------------------------
module ntrm_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  ntrm_pkg::item_t  push_item,
    input  logic             pop,
    output ntrm_pkg::item_t  head_item,
    output ntrm_pkg::qstat_t qstat
);
    import ntrm_pkg::*;

    item_t             slots [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign qstat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign qstat.empty = (count_reg == '0);
    assign head_item   = slots[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_ptr_reg] <= push_item;
    end

endmodule

### rtl/ntrm_back.sv
// ---------------------------------------------------------------------------
// ntrm_back
// distance accumulation, best and second tracking, ratio test
// ---------------------------------------------------------------------------
module ntrm_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ntrm_pkg::item_t                head_item,
    input  ntrm_pkg::qstat_t               qstat,
    output logic                           pop,
    input  logic [ntrm_pkg::RATIO_W-1:0]   ratio,
    output logic                           result_valid,
    input  logic                           result_stall,
    output logic                           match_found,
    output logic [ntrm_pkg::IDX_W-1:0]     match_index
);
    import ntrm_pkg::*;

    logic advance;

    // squaring stage
    logic               s1_valid_reg;
    logic               s1_cmd_reg;
    logic               s1_last_elem_reg;
    logic               s1_last_cand_reg;
    logic [IDX_W-1:0]   s1_idx_reg;
    logic [SQ_W-1:0]    s1_sq_reg;
    logic signed [ELEM_W:0]     diff;
    logic signed [2*ELEM_W+1:0] diff_sq;

    // search state
    logic [DIST_W-1:0] acc_reg,    acc_next;
    logic [DIST_W-1:0] best_reg,   best_next;
    logic [DIST_W-1:0] second_reg, second_next;
    logic [IDX_W-1:0]  bidx_reg,   bidx_next;
    logic [1:0]        seen_reg,   seen_next;
    logic [DIST_W:0]   sum;
    logic [DIST_W-1:0] acc_sum;
    logic [DIST_W-1:0] best_upd;
    logic [DIST_W-1:0] second_upd;
    logic [IDX_W-1:0]  bidx_upd;
    logic [1:0]        seen_upd;

    // finished search snapshot
    logic              r_valid_reg, r_valid_next;
    logic              r_ok_reg;
    logic [DIST_W-1:0] r_best_reg;
    logic [DIST_W-1:0] r_second_reg;
    logic [IDX_W-1:0]  r_idx_reg;

    // ratio product stage
    logic              t_valid_reg;
    logic              t_ok_reg;
    logic [IDX_W-1:0]  t_idx_reg;
    logic [PROD_W-1:0] t_prod_reg;
    logic [PROD_W-1:0] t_bsh_reg;

    // result register
    logic              out_valid_reg;
    logic              found_reg;
    logic [IDX_W-1:0]  index_reg;
    logic              found;

    assign advance = !out_valid_reg || !result_stall;
    assign pop     = advance && !qstat.empty;

    assign diff    = (ELEM_W+1)'(head_item.elem) - (ELEM_W+1)'(head_item.qval);
    assign diff_sq = (2*ELEM_W+2)'(diff) * (2*ELEM_W+2)'(diff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (advance)
            s1_valid_reg <= !qstat.empty;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_cmd_reg       <= head_item.cmd;
            s1_last_elem_reg <= head_item.last_elem;
            s1_last_cand_reg <= head_item.last_cand;
            s1_idx_reg       <= head_item.idx;
            s1_sq_reg        <= diff_sq[SQ_W-1:0];
        end
    end

    always_comb
    begin
        sum     = {1'b0, acc_reg} + (DIST_W+1)'(s1_sq_reg);
        acc_sum = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];

        best_upd   = best_reg;
        second_upd = second_reg;
        bidx_upd   = bidx_reg;
        if (acc_sum < best_reg)
        begin
            second_upd = best_reg;
            best_upd   = acc_sum;
            bidx_upd   = s1_idx_reg;
        end
        else if (acc_sum < second_reg)
        begin
            second_upd = acc_sum;
        end
        seen_upd = (seen_reg == SEEN_MAX) ? SEEN_MAX : seen_reg + 2'd1;

        acc_next     = acc_reg;
        best_next    = best_reg;
        second_next  = second_reg;
        bidx_next    = bidx_reg;
        seen_next    = seen_reg;
        r_valid_next = 1'b0;

        if (s1_valid_reg)
        begin
            if (s1_cmd_reg == CMD_QUERY)
            begin
                acc_next = '0;
                if (s1_last_elem_reg)
                begin
                    best_next   = DIST_MAX;
                    second_next = DIST_MAX;
                    bidx_next   = '0;
                    seen_next   = '0;
                end
            end
            else if (!s1_last_elem_reg)
            begin
                acc_next = acc_sum;
            end
            else
            begin
                acc_next = '0;
                if (s1_last_cand_reg)
                begin
                    r_valid_next = 1'b1;
                    best_next    = DIST_MAX;
                    second_next  = DIST_MAX;
                    bidx_next    = '0;
                    seen_next    = '0;
                end
                else
                begin
                    best_next   = best_upd;
                    second_next = second_upd;
                    bidx_next   = bidx_upd;
                    seen_next   = seen_upd;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg     <= '0;
            best_reg    <= DIST_MAX;
            second_reg  <= DIST_MAX;
            bidx_reg    <= '0;
            seen_reg    <= '0;
            r_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            acc_reg     <= acc_next;
            best_reg    <= best_next;
            second_reg  <= second_next;
            bidx_reg    <= bidx_next;
            seen_reg    <= seen_next;
            r_valid_reg <= r_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            r_ok_reg     <= (seen_upd == SEEN_MAX);
            r_best_reg   <= best_upd;
            r_second_reg <= second_upd;
            r_idx_reg    <= bidx_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            t_valid_reg   <= r_valid_reg;
            out_valid_reg <= t_valid_reg;
        end
    end

    // best << 15 against second * ratio
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            t_ok_reg   <= r_ok_reg;
            t_idx_reg  <= r_idx_reg;
            t_prod_reg <= PROD_W'(r_second_reg) * PROD_W'(ratio);
            t_bsh_reg  <= PROD_W'({r_best_reg, {ONE_SHIFT{1'b0}}});
        end
    end

    assign found = t_ok_reg && (t_bsh_reg < t_prod_reg);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            found_reg <= found;
            index_reg <= found ? t_idx_reg : '0;
        end
    end

    assign result_valid = out_valid_reg;
    assign match_found  = found_reg;
    assign match_index  = index_reg;

endmodule

### rtl/ntrm_checker.sv
// ---------------------------------------------------------------------------
// ntrm_checker
// port level checks of the matcher, bound to the top level
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ntrm_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       result_valid,
    input logic                       result_stall,
    input logic                       match_found,
    input logic [ntrm_pkg::IDX_W-1:0] match_index
);
    // held result keeps its payload
    `ASSERT_CLK(a_result_hold, result_valid && result_stall |=> result_valid && $stable(match_found) && $stable(match_index), "stalled result changed")

    // no match carries a zero index
    `ASSERT_CLK(a_nomatch_zero, result_valid && !match_found |-> match_index == '0, "index without match")

    // nothing pending once reset has been seen
    `ASSERT_RST(a_reset_quiet, !rst_n |=> !result_valid, "result during reset")

endmodule

bind nearest_two_ratio_matcher ntrm_checker u_checker (.*);

### tb/sv/ntrm_tb_pkg.sv
// ---------------------------------------------------------------------------
// ntrm_tb_pkg
// scoreboard of the nearest two ratio matcher testbench
//
// keeps its own copy of the query store, the element position and the
// nearest two search, works out the outcome of every final candidate
// request and checks the results of the block in order against it
// ---------------------------------------------------------------------------
package ntrm_tb_pkg;

    import ntrm_pkg::*;

    localparam int DESC_LEN    = 64;
    localparam int PRINT_LIMIT = 200;

    typedef logic signed [ELEM_W-1:0] elem_q_t [$];

    typedef struct {
        logic             found;
        logic [IDX_W-1:0] index;
    } match_t;

    class ratio_match_scoreboard;

        logic signed [ELEM_W-1:0]      query_mem [DESC_LEN];
        logic [$clog2(DESC_LEN)-1:0]   pos;
        logic [DIST_W-1:0]             accum;
        logic [DIST_W-1:0]             best;
        logic [DIST_W-1:0]             second;
        logic [IDX_W-1:0]              best_idx;
        logic [1:0]                    seen;
        logic [RATIO_W-1:0]            ratio;
        match_t                        expected_matches [$];
        int                            errors;

        function new();
            ratio  = RATIO_RESET;
            pos    = '0;
            errors = 0;
            foreach (query_mem[i])
                query_mem[i] = '0;
            clear_search();
        endfunction

        function void clear_search();
            accum    = '0;
            best     = DIST_MAX;
            second   = DIST_MAX;
            best_idx = '0;
            seen     = '0;
        endfunction

        function void set_ratio(logic [RATIO_W-1:0] value);
            ratio = value;
        endfunction

        function int pending();
            return expected_matches.size();
        endfunction

        function void step_pos(logic le);
            if (le || pos == DESC_LEN - 1)
                pos = '0;
            else
                pos = pos + 1'b1;
        endfunction

        function void note_request(logic c, logic signed [ELEM_W-1:0] v,
                                   logic [IDX_W-1:0] idx, logic le, logic lc);
            int          diff;
            logic [63:0] mag;
            logic [63:0] sum;
            logic [63:0] lhs;
            logic [63:0] rhs;
            match_t      m;
            if (c == CMD_QUERY)
            begin
                query_mem[pos] = v;
                accum = '0;
                if (le)
                    clear_search();
                step_pos(le);
                return;
            end
            diff  = int'(v) - int'(query_mem[pos]);
            mag   = (diff < 0) ? 64'(-diff) : 64'(diff);
            sum   = 64'(accum) + mag * mag;
            // running distance saturates
            accum = (sum > 64'(DIST_MAX)) ? DIST_MAX : sum[DIST_W-1:0];
            step_pos(le);
            if (!le)
                return;
            if (accum < best)
            begin
                second   = best;
                best     = accum;
                best_idx = idx;
            end
            else if (accum < second)
            begin
                second = accum;
            end
            if (seen < SEEN_MAX)
                seen = seen + 1'b1;
            accum = '0;
            if (!lc)
                return;
            lhs     = 64'(best) << ONE_SHIFT;
            rhs     = 64'(second) * 64'(ratio);
            m.found = (seen >= SEEN_MAX) && (lhs < rhs);
            m.index = m.found ? best_idx : '0;
            expected_matches.insert(expected_matches.size(), m);
            clear_search();
        endfunction

        task report(string msg);
            if (errors < PRINT_LIMIT)
                $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(logic found, logic [IDX_W-1:0] index);
            match_t want;
            if (expected_matches.size() == 0)
            begin
                report($sformatf("unexpected result found=%0b index=%0d", found, index));
                return;
            end
            want = expected_matches.pop_front();
            if (found !== want.found)
                report($sformatf("match_found %0b, wanted %0b", found, want.found));
            if (index !== want.index)
                report($sformatf("match_index %0d, wanted %0d", index, want.index));
        endtask

    endclass

endpackage

### tb/sv/nearest_two_ratio_matcher_tb.sv
// ---------------------------------------------------------------------------
// nearest_two_ratio_matcher_tb
// self-checking testbench of the nearest two ratio matcher
//
// loads a full query, then drives a short directed run (saturating distance,
// position wrap, ties, single element candidate, query request inside a candidate)
// followed by random queries with near, exact, duplicate and random
// candidates mixed with noise requests, over several ratio settings and
// idling patterns on both channels; every result is checked in order
// against the scoreboard
// ---------------------------------------------------------------------------
module nearest_two_ratio_matcher_tb;

    import ntrm_pkg::*;
    import ntrm_tb_pkg::*;

    localparam int ITEMS_PER_PHASE = 185;
    localparam int PHASES          = 6;
    localparam int SETTLE_CYCLES   = 20;
    localparam int QUIET_LIMIT     = 2000;

    logic                     clk;
    logic                     rst_n        = 1'b0;
    logic                     item_valid   = 1'b0;
    logic                     item_stall;
    logic                     cmd          = CMD_QUERY;
    logic signed [ELEM_W-1:0] elem_value   = '0;
    logic [IDX_W-1:0]         cand_index   = '0;
    logic                     last_elem    = 1'b0;
    logic                     last_cand    = 1'b0;
    logic                     result_valid;
    logic                     result_stall = 1'b0;
    logic                     match_found;
    logic [IDX_W-1:0]         match_index;
    logic                     ratio_we     = 1'b0;
    logic [RATIO_W-1:0]       ratio_wdata  = '0;

    ratio_match_scoreboard sb;
    int send_idle_pct = 10;
    int recv_idle_pct = 82;
    int sent_count    = 0;

    nearest_two_ratio_matcher dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .cmd          (cmd),
        .elem_value   (elem_value),
        .cand_index   (cand_index),
        .last_elem    (last_elem),
        .last_cand    (last_cand),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .match_found  (match_found),
        .match_index  (match_index),
        .ratio_we     (ratio_we),
        .ratio_wdata  (ratio_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        result_stall <= ($urandom_range(0, 99) < recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && item_valid && !item_stall)
            sb.note_request(cmd, elem_value, cand_index, last_elem, last_cand);
        if (rst_n && result_valid && !result_stall)
            sb.check_result(match_found, match_index);
    end

    task automatic send_request(input logic c, input logic signed [ELEM_W-1:0] v,
                                input logic [IDX_W-1:0] idx, input logic le,
                                input logic lc);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        cmd        <= c;
        elem_value <= v;
        cand_index <= idx;
        last_elem  <= le;
        last_cand  <= lc;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        sent_count++;
    endtask

    task automatic send_descriptor(input logic c, input elem_q_t vals,
                                   input logic [IDX_W-1:0] idx, input logic lc_last);
        for (int i = 0; i < vals.size(); i++)
        begin
            if (i == vals.size() - 1)
                send_request(c, vals[i], idx, 1'b1, lc_last);
            else
                send_request(c, vals[i], IDX_W'($urandom), 1'b0, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic wait_results_drained();
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic let_block_settle();
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_ratio(input logic [RATIO_W-1:0] value);
        ratio_we    <= 1'b1;
        ratio_wdata <= value;
        @(posedge clk);
        ratio_we    <= 1'b0;
        sb.set_ratio(value);
    endtask

    task automatic run_directed();
        elem_q_t v;
        v = {};
        repeat (DESC_LEN) v.insert(v.size(), 16'sh8000);
        send_descriptor(CMD_QUERY, v, '0, 1'b0);
        // long enough to saturate, position wraps twice
        v = {};
        repeat (130) v.insert(v.size(), 16'sh7fff);
        send_descriptor(CMD_CAND, v, 16'hffff, 1'b0);
        v = '{16'sh8000};
        send_descriptor(CMD_CAND, v, 16'h0000, 1'b1);
        v = '{16'sh7fff, 16'sh0000};
        send_descriptor(CMD_QUERY, v, '0, 1'b0);
        // equal distances, earlier one stays best
        send_descriptor(CMD_CAND, v, 16'd5, 1'b0);
        send_descriptor(CMD_CAND, v, 16'd9, 1'b1);
        v = '{16'sh0000, 16'sh0000};
        send_descriptor(CMD_CAND, v, 16'd3, 1'b1);
        // query request breaking into a candidate
        send_request(CMD_CAND, 16'sh7fff, 16'd7, 1'b0, 1'b1);
        send_request(CMD_QUERY, 16'sh0001, 16'd0, 1'b0, 1'b0);
        send_request(CMD_QUERY, 16'sh1234, 16'd0, 1'b1, 1'b1);
        v = '{16'sh7fff, 16'sh0001};
        send_descriptor(CMD_CAND, v, 16'd1, 1'b0);
        v = '{16'sh8000, 16'sh8001};
        send_descriptor(CMD_CAND, v, 16'hffff, 1'b1);
    endtask

    task automatic send_group();
        elem_q_t          qv;
        elem_q_t          cv;
        elem_q_t          prev;
        int               len;
        int               clen;
        int               ncand;
        int               kind;
        int               span;
        int               jitter;
        logic [IDX_W-1:0] idx;
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(9, DESC_LEN) : $urandom_range(2, 8);
        qv = {};
        repeat (len) qv.insert(qv.size(), ELEM_W'($urandom));
        send_descriptor(CMD_QUERY, qv, IDX_W'($urandom), 1'b0);
        ncand = $urandom_range(1, 5);
        prev  = qv;
        for (int n = 0; n < ncand; n++)
        begin
            kind = $urandom_range(0, 9);
            span = (kind < 3) ? 4 : 600;
            clen = ($urandom_range(0, 9) == 0) ? $urandom_range(1, len + 3) : len;
            cv   = {};
            for (int i = 0; i < clen; i++)
            begin
                jitter = int'($urandom_range(0, 2 * span)) - span;
                if (kind == 0)
                    cv.insert(cv.size(), qv[i % len]);
                else if (kind < 6)
                    cv.insert(cv.size(), ELEM_W'(int'(qv[i % len]) + jitter));
                else if (kind < 8)
                    cv.insert(cv.size(), ELEM_W'($urandom));
                else
                    cv.insert(cv.size(), prev[i % prev.size()]);
            end
            case ($urandom_range(0, 7))
                0:       idx = '0;
                1:       idx = '1;
                default: idx = IDX_W'($urandom);
            endcase
            send_descriptor(CMD_CAND, cv, idx, n == ncand - 1);
            prev = cv;
        end
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 6))
            send_request(1'($urandom_range(0, 1)), ELEM_W'($urandom), IDX_W'($urandom),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        logic [RATIO_W-1:0] ratio_val;
        int                 target;
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        for (int phase = 0; phase < PHASES; phase++)
        begin
            let_block_settle();
            case (phase)
                0:       ratio_val = 16'hffff;
                1:       ratio_val = 16'h0000;
                2:       ratio_val = 16'd32768;
                3:       ratio_val = RATIO_W'($urandom);
                4:       ratio_val = RATIO_RESET;
                default: ratio_val = RATIO_W'($urandom_range(9830, 29491));
            endcase
            write_ratio(ratio_val);
            send_idle_pct = (phase < 2) ? 10 : (phase < 4) ? 82 : 0;
            recv_idle_pct = (phase < 2) ? 82 : (phase < 4) ? 10 : 0;
            target = sent_count + ITEMS_PER_PHASE;
            while (sent_count < target)
            begin
                if ($urandom_range(0, 99) < 85)
                    send_group();
                else
                    send_noise();
                if ($urandom_range(0, 9) == 0)
                    wait_results_drained();
            end
        end
        let_block_settle();
        if (sb.errors == 0)
            $display("nearest_two_ratio_matcher_tb: clean");
        else
            $display("nearest_two_ratio_matcher_tb: errors");
        $finish;
    end

    // stop when neither channel has moved for a long stretch
    initial
    begin
        int quiet;
        quiet = 0;
        wait (rst_n === 1'b1);
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("nearest_two_ratio_matcher_tb: errors");
        $finish;
    end

endmodule
